// ===== sv/bad_pkg.sv =====
// Shared types and constants for the box average downsampler.
package bad_pkg;
  localparam int unsigned CHANS = 4;
  // Largest block edge; the sum and count widths below are sized for it.
  localparam int unsigned MAX_FACTOR = 16;
  localparam int unsigned SUM_W = 16;
  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [CHANS-1:0] sums_t;
  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ALPHA  = 2'd3;
  // Final step of a block, handed from the accumulator to the divider.
  typedef struct packed {
    sums_t        sums;
    logic [8:0]   cnt;
    logic [11:0]  col;
    logic [11:0]  row;
    logic         frame_end;
    logic         alpha;
  } blk_t;
endpackage

// ===== sv/bad_div.sv =====
// Iterative restoring divider for four block sums by the block pixel count.
module bad_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bad_pkg::blk_t  blk,
  output logic           busy,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [11:0]    out_col,
  output logic [11:0]    out_row,
  output logic [7:0]     avg0,
  output logic [7:0]     avg1,
  output logic [7:0]     avg2,
  output logic [7:0]     avg3,
  output logic           out_frame_end
);
  import bad_pkg::*;
  // Quotients fit in 8 bits, so 8 steps: one quotient bit per step per channel.
  logic            run_r;
  logic [2:0]      step_r;
  blk_t            b_r;
  logic [8:0]      rem_r [CHANS];
  logic [7:0]      q_r   [CHANS];
  logic            ov_r;
  logic [7:0]      res_r [CHANS];
  logic [11:0]     col_r, row_r;
  logic            fe_r;
  logic [9:0]      trial [CHANS];
  logic [8:0]      rem_nxt [CHANS];
  logic [7:0]      q_nxt [CHANS];
  logic [3:0]      bitpos;

  assign bitpos = 4'd7 - {1'b0, step_r};
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      trial[c] = {rem_r[c], b_r.sums[c][bitpos]};
      q_nxt[c] = q_r[c];
      if (trial[c] >= {1'b0, b_r.cnt}) begin
        rem_nxt[c] = 9'(trial[c] - {1'b0, b_r.cnt});
        q_nxt[c][bitpos[2:0]] = 1'b1;
      end else begin
        rem_nxt[c] = trial[c][8:0];
      end
    end
  end

  // Sums are below 256*cnt, so the top eight bits are a valid starting remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ov_r  <= 1'b0;
      step_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        b_r    <= blk;
        for (int c = 0; c < CHANS; c++) begin
          rem_r[c] <= {1'b0, blk.sums[c][15:8]};
          q_r[c]   <= '0;
        end
      end else if (run_r && !(ov_r && !out_ready && step_r == 3'd7)) begin
        for (int c = 0; c < CHANS; c++) begin
          rem_r[c] <= rem_nxt[c];
          q_r[c]   <= q_nxt[c];
        end
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          run_r <= 1'b0;
          ov_r  <= 1'b1;
          // The alpha mean reads as zero when alpha is off.
          for (int c = 0; c < CHANS; c++)
            res_r[c] <= (c == CHANS - 1 && !b_r.alpha) ? 8'd0 : q_nxt[c];
          col_r <= b_r.col;
          row_r <= b_r.row;
          fe_r  <= b_r.frame_end;
        end
      end
    end
  end

  assign busy = run_r;
  assign out_valid = ov_r;
  assign out_col = col_r;
  assign out_row = row_r;
  assign avg0 = res_r[0];
  assign avg1 = res_r[1];
  assign avg2 = res_r[2];
  assign avg3 = res_r[3];
  assign out_frame_end = fe_r;
endmodule

// ===== sv/box_average_downsampler.sv =====
// Box average downsampler top level: position tracking, line store and result divider.
// Path: a block's last pixel passes through s1_r and pend_r into the divider, whose
// last step raises out_valid. A pixel is taken only after its predecessor's line store
// write; a pixel that closes a block holds input until the divider is done and its word
// has been taken by the receiver. Synchronous reset restores register defaults and
// frame start; line store contents are not cleared.
module box_average_downsampler #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_chan0,
  input  logic [7:0]  in_chan1,
  input  logic [7:0]  in_chan2,
  input  logic [7:0]  in_chan3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_col,
  output logic [11:0] out_row,
  output logic [7:0]  out_avg0,
  output logic [7:0]  out_avg1,
  output logic [7:0]  out_avg2,
  output logic [7:0]  out_avg3,
  output logic        out_frame_end
);
  import bad_pkg::*;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned FW = $clog2(MAX_FACTOR + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [4:0]  factor_r;
  logic [12:0] width_r, height_r;
  logic        alpha_r;
  logic [FW-1:0] f, cib_r, rib_r, cib_nxt, rib_nxt;
  logic [CW-1:0] w, col_r, col_nxt, bcf_r;
  logic [RW-1:0] h, row_r, row_nxt, brf_r;
  logic [AW-1:0] bc_r;
  logic [11:0]   br_r;

  // Clamp the registers into their legal ranges.
  always_comb begin
    f = (factor_r == '0) ? FW'(1)
        : ((32'(factor_r) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(factor_r));
    w = (width_r == '0) ? CW'(1)
        : ((32'(width_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_r));
    h = (height_r == '0) ? RW'(1)
        : ((32'(height_r) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_r));
  end

  // Stage 1: the accepted pixel's read is in flight. Stage 2: sums arrive, write back.
  logic s1_r;
  logic [7:0] px_r [CHANS];
  logic first_r, lastx_r, lasty_r, fe1_r;
  logic [AW-1:0] a1_r;
  logic [11:0] br1_r;
  logic [FW-1:0] bw_r, bh_r;
  logic div_busy, pend_r;
  blk_t blk_r;
  sums_t mem [MAX_WIDTH];
  sums_t rd_r, wsum;

  logic accept;
  logic [CW-1:0] bwf;
  logic [RW-1:0] bhf;
  logic [FW-1:0] bw, bh;
  logic lastx, lasty;

  assign in_ready = rst_n && !cfg_we && !s1_r && !pend_r && !div_busy && !out_valid;
  assign accept = in_valid && in_ready;

  always_comb begin
    bwf = w - bcf_r;
    bhf = h - brf_r;
    bw = (bwf > CW'(f)) ? f : FW'(bwf);
    bh = (bhf > RW'(f)) ? f : FW'(bhf);
    lastx = (cib_r + FW'(1) >= bw) || (col_r + CW'(1) == w);
    lasty = (rib_r + FW'(1) >= bh) || (row_r + RW'(1) == h);
    cib_nxt = (cib_r + FW'(1) >= f) ? '0 : cib_r + FW'(1);
    col_nxt = col_r + CW'(1);
    rib_nxt = rib_r;
    row_nxt = row_r;
    if (col_nxt >= w) begin
      col_nxt = '0;
      cib_nxt = '0;
      rib_nxt = (rib_r + FW'(1) >= f) ? '0 : rib_r + FW'(1);
      row_nxt = row_r + RW'(1);
      if (row_nxt >= h) begin
        row_nxt = '0;
        rib_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= 5'd1; width_r <= 13'd4096; height_r <= 13'd4096; alpha_r <= 1'b0;
      col_r <= '0; row_r <= '0; cib_r <= '0; rib_r <= '0;
      bcf_r <= '0; brf_r <= '0; bc_r <= '0; br_r <= '0;
      s1_r <= 1'b0; pend_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FACTOR: factor_r <= cfg_data[4:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_ALPHA:  alpha_r  <= cfg_data[0];
        default: ;
      endcase
      col_r <= '0; row_r <= '0; cib_r <= '0; rib_r <= '0;
      bcf_r <= '0; brf_r <= '0; bc_r <= '0; br_r <= '0;
    end else begin
      s1_r <= accept;
      pend_r <= s1_r && lastx_r && lasty_r;
      if (accept) begin
        px_r[0] <= in_chan0; px_r[1] <= in_chan1; px_r[2] <= in_chan2;
        px_r[3] <= alpha_r ? in_chan3 : 8'd0;
        first_r <= (cib_r == '0) && (rib_r == '0);
        lastx_r <= lastx; lasty_r <= lasty;
        fe1_r <= (col_r + CW'(1) == w) && (row_r + RW'(1) == h);
        a1_r <= bc_r; br1_r <= br_r; bw_r <= bw; bh_r <= bh;
        col_r <= col_nxt; row_r <= row_nxt; cib_r <= cib_nxt; rib_r <= rib_nxt;
        // Block position advances with the counters instead of dividing.
        if (col_nxt == '0) begin
          bcf_r <= '0; bc_r <= '0;
          if (row_nxt == '0) begin
            brf_r <= '0; br_r <= '0;
          end else if (rib_nxt == '0) begin
            brf_r <= brf_r + RW'(f); br_r <= br_r + 12'd1;
          end
        end else if (cib_nxt == '0) begin
          bcf_r <= bcf_r + CW'(f); bc_r <= bc_r + AW'(1);
        end
      end
    end
  end

  // Line store: one entry of four channel sums per block column.
  always_ff @(posedge clk) begin
    if (accept) rd_r <= mem[bc_r];
    if (s1_r) mem[a1_r] <= wsum;
  end

  always_comb begin
    for (int c = 0; c < CHANS; c++)
      wsum[c] = (first_r ? '0 : rd_r[c]) + SUM_W'(px_r[c]);
  end

  // Snapshot of the current block, registered with every write back; the divider takes it when pend_r starts it.
  always_ff @(posedge clk) begin
    if (s1_r) begin
      blk_r.sums <= wsum;
      blk_r.cnt <= 9'(bw_r) * 9'(bh_r);
      blk_r.col <= 12'(a1_r); blk_r.row <= br1_r;
      blk_r.frame_end <= fe1_r; blk_r.alpha <= alpha_r;
    end
  end

  bad_div u_div (
    .clk, .rst_n, .start(pend_r), .blk(blk_r), .busy(div_busy),
    .out_ready, .out_valid, .out_col, .out_row,
    .avg0(out_avg0), .avg1(out_avg1), .avg2(out_avg2), .avg3(out_avg3),
    .out_frame_end
  );
endmodule

// ===== tb/box_average_downsampler_tb.sv =====
// Self-checking testbench for the box average downsampler.
module box_average_downsampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bad_pkg::*;

  // One averaged output word as the block should produce it.
  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [7:0]  a3;
    logic        fe;
  } avg_word_t;

  typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

  // One row of the directed table. Rows with known set carry a hand-written word.
  typedef struct {
    step_kind_t  kind;
    logic [1:0]  idx;
    logic [12:0] data;
    logic [7:0]  ch [4];
    bit          known;
    avg_word_t   word;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_chan0 = '0, in_chan1 = '0, in_chan2 = '0, in_chan3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_col, out_row;
  logic [7:0]  out_avg0, out_avg1, out_avg2, out_avg3;
  logic        out_frame_end;

  box_average_downsampler dut (.*);

  always #5 clk = ~clk;

  // Shadow of the block: raw register values, position counters and line sums.
  logic [4:0]  sh_factor;
  logic [12:0] sh_width, sh_height;
  logic        sh_alpha;
  int unsigned pos_col, pos_row, in_blk_col, in_blk_row;
  int unsigned line_sums [4096][4];

  avg_word_t   pending_avgs[$];
  step_t       plan[$];
  int          fail_count = 0;
  int          snd_idle = 0, rcv_idle = 0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          quiet_cycles = 0;
  int          pix_total = 0;

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the shadow by one pixel; returns 1 when the pixel closes a block.
  function automatic bit average_pixel(input logic [7:0] ch [4], output avg_word_t w);
    int unsigned f, wd, ht, bc, br, bw, bh, cnt, s, col, row;
    bit lx, ly, done;
    f  = clamp_cfg(sh_factor, 16);
    wd = clamp_cfg(sh_width, 4096);
    ht = clamp_cfg(sh_height, 4096);
    col = pos_col;
    row = pos_row;
    done = 0;
    w = '0;
    if (col >= wd || row >= ht) begin
      col = 0; row = 0; in_blk_col = 0; in_blk_row = 0;
    end
    bc = col / f;
    br = row / f;
    for (int c = 0; c < 4; c++) begin
      s = (c == 3 && !sh_alpha) ? 0 : ch[c];
      if (in_blk_col == 0 && in_blk_row == 0) line_sums[bc][c] = s;
      else line_sums[bc][c] += s;
    end
    bw = wd - bc * f;
    if (bw > f) bw = f;
    bh = ht - br * f;
    if (bh > f) bh = f;
    lx = (in_blk_col + 1 >= bw) || (col + 1 == wd);
    ly = (in_blk_row + 1 >= bh) || (row + 1 == ht);
    if (lx && ly) begin
      cnt = bw * bh;
      w.col = bc[11:0];
      w.row = br[11:0];
      w.a0 = 8'(line_sums[bc][0] / cnt);
      w.a1 = 8'(line_sums[bc][1] / cnt);
      w.a2 = 8'(line_sums[bc][2] / cnt);
      w.a3 = sh_alpha ? 8'(line_sums[bc][3] / cnt) : 8'd0;
      w.fe = (col + 1 == wd && row + 1 == ht);
      done = 1;
    end
    in_blk_col++;
    if (in_blk_col >= f) in_blk_col = 0;
    col++;
    if (col >= wd) begin
      col = 0;
      in_blk_col = 0;
      in_blk_row++;
      if (in_blk_row >= f) in_blk_row = 0;
      row++;
      if (row >= ht) begin
        row = 0;
        in_blk_row = 0;
      end
    end
    pos_col = col;
    pos_row = row;
    return done;
  endfunction

  // Registers change only with the block idle: wait for the last word, then let
  // a pixel that closes no block drain through the pipeline before writing.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    wait (pending_avgs.size() == 0);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FACTOR: sh_factor = val[4:0];
      REG_WIDTH:  sh_width  = val;
      REG_HEIGHT: sh_height = val;
      REG_ALPHA:  sh_alpha  = val[0];
    endcase
    pos_col = 0; pos_row = 0; in_blk_col = 0; in_blk_row = 0;
  endtask

  // Offer one pixel and hold it until accepted; called and left at a falling edge.
  task automatic send_pixel(input logic [7:0] ch [4], input bit known, input avg_word_t kw);
    avg_word_t w;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_chan0 = ch[0];
    in_chan1 = ch[1];
    in_chan2 = ch[2];
    in_chan3 = ch[3];
    do @(posedge clk); while (!in_ready);
    if (average_pixel(ch, w)) pending_avgs.push_back(known ? kw : w);
    pix_total++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_pixel();
    logic [7:0] ch [4];
    for (int c = 0; c < 4; c++) ch[c] = rand_sample();
    send_pixel(ch, 1'b0, '0);
  endtask

  function automatic void add_cfg(logic [1:0] idx, logic [12:0] val);
    step_t s;
    s = '{kind: STEP_CFG, idx: idx, data: val, ch: '{0, 0, 0, 0}, known: 0, word: '0};
    plan.push_back(s);
  endfunction

  function automatic void add_pix(logic [7:0] c0, c1, c2, c3, bit known, avg_word_t w);
    step_t s;
    s = '{kind: STEP_PIX, idx: 0, data: 0, ch: '{c0, c1, c2, c3}, known: known, word: w};
    plan.push_back(s);
  endfunction

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (stall_req) begin
      out_ready <= 1'b0;
      repeat (300) @(negedge clk);
      stall_req = 1'b0;
    end
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Compare every accepted word against the oldest predicted one.
  always @(posedge clk) begin
    avg_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_avgs.size() == 0) begin
        $error("unexpected word col=%0d row=%0d", out_col, out_row);
        fail_count++;
      end else begin
        e = pending_avgs.pop_front();
        if (out_col != e.col) begin
          $error("out_col expected %0d got %0d", e.col, out_col); fail_count++;
        end
        if (out_row != e.row) begin
          $error("out_row expected %0d got %0d", e.row, out_row); fail_count++;
        end
        if (out_avg0 != e.a0) begin
          $error("out_avg0 expected %0d got %0d", e.a0, out_avg0); fail_count++;
        end
        if (out_avg1 != e.a1) begin
          $error("out_avg1 expected %0d got %0d", e.a1, out_avg1); fail_count++;
        end
        if (out_avg2 != e.a2) begin
          $error("out_avg2 expected %0d got %0d", e.a2, out_avg2); fail_count++;
        end
        if (out_avg3 != e.a3) begin
          $error("out_avg3 expected %0d got %0d", e.a3, out_avg3); fail_count++;
        end
        if (out_frame_end != e.fe) begin
          $error("out_frame_end expected %0d got %0d", e.fe, out_frame_end); fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    sh_factor = 5'd1;
    sh_width = 13'd4096;
    sh_height = 13'd4096;
    sh_alpha = 1'b0;
    pos_col = 0; pos_row = 0; in_blk_col = 0; in_blk_row = 0;

    // Directed table. Right after reset every pixel is its own block.
    add_pix(8'd0, 8'd0, 8'd0, 8'd0, 1, '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    // Alpha is ignored by default, so avg3 stays zero.
    add_pix(8'd255, 8'd255, 8'd255, 8'd255, 1,
            '{12'd1, 12'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0});
    // Enabling alpha restarts the frame at the origin.
    add_cfg(REG_ALPHA, 13'd1);
    add_pix(8'd255, 8'd128, 8'd1, 8'd255, 1,
            '{12'd0, 12'd0, 8'd255, 8'd128, 8'd1, 8'd255, 1'b0});
    // Zero factor, width and height all act as one: a 1x1 frame that wraps.
    add_cfg(REG_FACTOR, 13'd0);
    add_cfg(REG_WIDTH, 13'd0);
    add_cfg(REG_HEIGHT, 13'd0);
    add_pix(8'd7, 8'd8, 8'd9, 8'd10, 1, '{12'd0, 12'd0, 8'd7, 8'd8, 8'd9, 8'd10, 1'b1});
    add_pix(8'd1, 8'd2, 8'd3, 8'd4, 1, '{12'd0, 12'd0, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1});
    // An oversized factor saturates; the 3x2 frame is one clipped block.
    add_cfg(REG_FACTOR, 13'd31);
    add_cfg(REG_WIDTH, 13'd3);
    add_cfg(REG_HEIGHT, 13'd2);
    add_pix(8'd255, 8'd0, 8'd17, 8'd255, 0, '0);
    add_pix(8'd255, 8'd0, 8'd200, 8'd0, 0, '0);
    add_pix(8'd254, 8'd1, 8'd3, 8'd128, 0, '0);
    add_pix(8'd255, 8'd255, 8'd90, 8'd255, 0, '0);
    add_pix(8'd0, 8'd255, 8'd77, 8'd1, 0, '0);
    add_pix(8'd255, 8'd0, 8'd6, 8'd255, 0, '0);
    add_cfg(REG_ALPHA, 13'd0);
    add_pix(8'd10, 8'd20, 8'd30, 8'd255, 0, '0);
    add_pix(8'd0, 8'd0, 8'd0, 8'd255, 0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    snd_idle = 14;
    rcv_idle = 81;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        drop_valid();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].ch, plan[i].known, plan[i].word);
      end
    end

    // Extreme geometry: oversized width clamps to the maximum, single row,
    // largest factor. Only the start of the row is sent, without idling.
    snd_idle = 0;
    rcv_idle = 0;
    drop_valid();
    write_reg(REG_FACTOR, 13'd16);
    write_reg(REG_WIDTH, 13'd8191);
    write_reg(REG_HEIGHT, 13'd1);
    write_reg(REG_ALPHA, 13'd1);
    for (int i = 0; i < 300; i++) random_pixel();
    // Tallest frame with a one-pixel column; only its top part is sent.
    drop_valid();
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd8191);
    for (int i = 0; i < 40; i++) random_pixel();
    pix_total = 0;

    // Random phases: whole frames of random geometry, sometimes cut short or
    // run past the end so the frame wraps.
    while (pix_total < 1100) begin
      if (pix_total < 367) begin
        snd_idle = 14; rcv_idle = 81;
      end else if (pix_total < 734) begin
        snd_idle = 81; rcv_idle = 14;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      drop_valid();
      if ($urandom_range(3) == 0)
        write_reg(REG_FACTOR, ($urandom_range(5) == 0) ? 13'($urandom_range(31))
                                                        : 13'($urandom_range(1, 5)));
      else
        write_reg(REG_FACTOR, 13'($urandom_range(1, 6)));
      write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 13'($urandom_range(0, 1))
                                                    : 13'($urandom_range(1, 24)));
      write_reg(REG_HEIGHT, 13'($urandom_range(0, 10)));
      if ($urandom_range(1)) write_reg(REG_ALPHA, 13'($urandom_range(1)));
      n = clamp_cfg(sh_width, 4096) * clamp_cfg(sh_height, 4096);
      case ($urandom_range(3))
        0: n = $urandom_range(1, n);
        1: n = n + $urandom_range(1, n);
        default: ;
      endcase
      if (n > 200) n = 200;
      // Once in the unthrottled stretch, hold the receiver off so the block
      // fills up and stalls its input while pixels keep coming.
      if (snd_idle == 0 && !stall_done) begin
        stall_req = 1'b1;
        stall_done = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        random_pixel();
        // Now and then stop sending until every word has come back.
        if ($urandom_range(199) == 0) begin
          drop_valid();
          wait (pending_avgs.size() == 0);
          @(negedge clk);
        end
      end
    end

    drop_valid();
    wait (pending_avgs.size() == 0);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
